FILE: src/hcd_pkg.sv
// Shared types, codes and constants of the histogram chi distance block.
`timescale 1ns / 1ps
package hcd_pkg;

   localparam int MAX_CHANNELS_DEFAULT = 16384;
   localparam int BIN_WIDTH_DEFAULT    = 32;

   localparam int BIN_BITS   = 32;
   localparam int RANGE_BITS = 14;
   localparam int COUNT_BITS = 15;
   localparam int DIST_BITS  = 32;
   localparam int SUM_BITS   = 64;
   localparam int ROOT_BITS  = 44;
   localparam int CNT_BITS   = 6;

   // two quotient bits per divider step, one root or quotient bit per step after
   localparam int DIV_STEPS  = 32;
   localparam int ROOT_STEPS = 44;
   localparam int QDIV_STEPS = 44;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_RANGE = 2'd1;
   localparam logic [1:0] STATUS_SHORT     = 2'd2;
   localparam logic [1:0] STATUS_NO_BINS   = 2'd3;

   localparam logic REG_RANGE_LOW  = 1'b0;
   localparam logic REG_RANGE_HIGH = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_ACC,
      ST_SQRT,
      ST_QDIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic take;
      logic mul;
      logic div_step;
      logic acc;
      logic sqrt_init;
      logic sqrt_step;
      logic qdiv_init;
      logic qdiv_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic used;
      logic last;
      logic ok_now;
      logic last_held;
      logic ok_held;
      logic out_free;
   } sts_type;

endpackage

FILE: src/hcd_ctrl.sv
// Controller state machine sequencing bin intake, term division and the final root.
`timescale 1ns / 1ps
module hcd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hcd_pkg::sts_type sts,
   output hcd_pkg::cmd_type cmd
);

   hcd_pkg::state_type state_ff, state_in;
   logic [hcd_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic div_end, root_end, qdiv_end;

   assign div_end  = (cnt_ff == hcd_pkg::CNT_BITS'(hcd_pkg::DIV_STEPS - 1));
   assign root_end = (cnt_ff == hcd_pkg::CNT_BITS'(hcd_pkg::ROOT_STEPS - 1));
   assign qdiv_end = (cnt_ff == hcd_pkg::CNT_BITS'(hcd_pkg::QDIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hcd_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (sts.used) state_in = hcd_pkg::ST_MUL;
               else if (sts.last) state_in = sts.ok_now ? hcd_pkg::ST_SQRT : hcd_pkg::ST_OUT;
            end
         end
         hcd_pkg::ST_MUL:  state_in = hcd_pkg::ST_DIV;
         hcd_pkg::ST_DIV:  if (div_end) state_in = hcd_pkg::ST_ACC;
         hcd_pkg::ST_ACC: begin
            if (sts.last_held) state_in = sts.ok_held ? hcd_pkg::ST_SQRT : hcd_pkg::ST_OUT;
            else state_in = hcd_pkg::ST_IDLE;
         end
         hcd_pkg::ST_SQRT: if (root_end) state_in = hcd_pkg::ST_QDIV;
         hcd_pkg::ST_QDIV: if (qdiv_end) state_in = hcd_pkg::ST_OUT;
         hcd_pkg::ST_OUT:  if (sts.out_free) state_in = hcd_pkg::ST_IDLE;
         default:          state_in = hcd_pkg::ST_IDLE;
      endcase
   end

   // restart the step count on every state change
   always_comb begin
      cnt_in = (state_in != state_ff) ? '0 : cnt_ff + 1'b1;
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         hcd_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.take      = req_valid;
            cmd.sqrt_init = req_valid && !sts.used && sts.last && sts.ok_now;
         end
         hcd_pkg::ST_MUL:  cmd.mul = 1'b1;
         hcd_pkg::ST_DIV:  cmd.div_step = 1'b1;
         hcd_pkg::ST_ACC: begin
            cmd.acc       = 1'b1;
            cmd.sqrt_init = sts.last_held && sts.ok_held;
         end
         hcd_pkg::ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cmd.qdiv_init = root_end;
         end
         hcd_pkg::ST_QDIV: cmd.qdiv_step = 1'b1;
         hcd_pkg::ST_OUT:  cmd.out_load = sts.out_free;
         default:          cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcd_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: src/hcd_dp.sv
// Datapath: bin intake, squared difference, serial divider, sum, square root and count divider.
`timescale 1ns / 1ps
module hcd_dp #(
   parameter int MAX_CHANNELS = hcd_pkg::MAX_CHANNELS_DEFAULT,
   parameter int BIN_WIDTH    = hcd_pkg::BIN_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [hcd_pkg::BIN_BITS-1:0]       req_measured_bin,
   input  logic [hcd_pkg::BIN_BITS-1:0]       req_reference_bin,
   input  logic                               req_last_bin,
   input  logic [hcd_pkg::RANGE_BITS-1:0]     range_low,
   input  logic [hcd_pkg::RANGE_BITS-1:0]     range_high,
   input  hcd_pkg::cmd_type                   cmd,
   output hcd_pkg::sts_type                   sts,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [hcd_pkg::DIST_BITS-1:0]      rsp_distance,
   output logic [1:0]                         rsp_status,
   output logic [hcd_pkg::COUNT_BITS-1:0]     rsp_used_bins
);

   localparam int CW  = $clog2(MAX_CHANNELS + 1);
   localparam int XW  = (CW > hcd_pkg::RANGE_BITS) ? CW : hcd_pkg::RANGE_BITS;
   localparam int EBW = (BIN_WIDTH < hcd_pkg::BIN_BITS) ? BIN_WIDTH : hcd_pkg::BIN_BITS;
   localparam logic [hcd_pkg::BIN_BITS-1:0] BIN_MASK =
      {hcd_pkg::BIN_BITS{1'b1}} >> (hcd_pkg::BIN_BITS - EBW);
   localparam logic [XW-1:0] MAX_X = XW'(MAX_CHANNELS);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_CHANNELS);

   localparam int BB = hcd_pkg::BIN_BITS;
   localparam int SB = hcd_pkg::SUM_BITS;
   localparam int RB = hcd_pkg::ROOT_BITS;
   localparam int QB = hcd_pkg::COUNT_BITS;
   localparam int RADB = SB + 24;
   localparam int RREMB = RB + 2;

   // bin intake
   logic [CW-1:0] idx_ff, idx_in;
   logic [BB-1:0] m_w, r_w;
   logic [XW-1:0] idx_x, low_x, high_x;
   logic          in_range;
   logic [QB-1:0] count_ff, count_in, count_after;
   logic [1:0]    status_now, status_ff, status_in;
   logic          last_ff, last_in;
   logic [BB-1:0] d_ff, d_in, r_ff, r_in;

   // term divider
   logic [SB-1:0] num_ff, num_in;
   logic [BB-1:0] rem_ff, rem_in;

   // accumulator
   logic [SB-1:0] sum_ff, sum_in;
   logic [SB:0]   sum_wide;

   // root
   logic [RADB-1:0]  rad_ff, rad_in;
   logic [RREMB-1:0] rrem_ff, rrem_in;
   logic [RB-1:0]    root_ff, root_in;

   // count divider
   logic [RB-1:0] qnum_ff, qnum_in;
   logic [QB-1:0] qrem_ff, qrem_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [hcd_pkg::DIST_BITS-1:0] dist_ff, dist_in;
   logic [1:0]                    rstat_ff, rstat_in;
   logic [QB-1:0]                 rused_ff, rused_in;

   assign m_w    = req_measured_bin & BIN_MASK;
   assign r_w    = req_reference_bin & BIN_MASK;
   assign idx_x  = XW'(idx_ff);
   assign low_x  = XW'(range_low);
   assign high_x = XW'(range_high);
   assign in_range = (idx_x < MAX_X) && (idx_x >= low_x) && (idx_x <= high_x);
   assign count_after = count_ff + QB'(in_range && (r_w != '0));

   always_comb begin
      if (range_low >= range_high) status_now = hcd_pkg::STATUS_BAD_RANGE;
      else if ((idx_x < high_x) || (high_x >= MAX_X)) status_now = hcd_pkg::STATUS_SHORT;
      else if (count_after == '0) status_now = hcd_pkg::STATUS_NO_BINS;
      else status_now = hcd_pkg::STATUS_OK;
   end

   assign sts.used      = in_range && (r_w != '0);
   assign sts.last      = req_last_bin;
   assign sts.ok_now    = (status_now == hcd_pkg::STATUS_OK);
   assign sts.last_held = last_ff;
   assign sts.ok_held   = (status_ff == hcd_pkg::STATUS_OK);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      idx_in    = idx_ff;
      count_in  = count_ff;
      status_in = status_ff;
      last_in   = last_ff;
      d_in      = d_ff;
      r_in      = r_ff;
      if (cmd.take) begin
         d_in      = (m_w > r_w) ? m_w - r_w : r_w - m_w;
         r_in      = r_w;
         last_in   = req_last_bin;
         status_in = status_now;
         count_in  = count_after;
         if (req_last_bin) idx_in = '0;
         else if (idx_ff < MAX_C) idx_in = idx_ff + 1'b1;
      end
      if (cmd.out_load) count_in = '0;
   end

   // restoring divide of the squared difference by the reference, two bits a step
   always_comb begin
      logic [BB-1:0] rem_t;
      logic [SB-1:0] num_t;
      logic [BB:0]   trial;
      rem_t = rem_ff;
      num_t = num_ff;
      for (int k = 0; k < 2; k++) begin
         trial = {rem_t, num_t[SB-1]};
         if (trial >= {1'b0, r_ff}) begin
            rem_t = BB'(trial - {1'b0, r_ff});
            num_t = {num_t[SB-2:0], 1'b1};
         end else begin
            rem_t = trial[BB-1:0];
            num_t = {num_t[SB-2:0], 1'b0};
         end
      end
      num_in = num_ff;
      rem_in = rem_ff;
      if (cmd.mul) begin
         num_in = SB'(d_ff) * SB'(d_ff);
         rem_in = '0;
      end else if (cmd.div_step) begin
         num_in = num_t;
         rem_in = rem_t;
      end
   end

   // saturating accumulate of the quotient
   assign sum_wide = {1'b0, sum_ff} + {1'b0, num_ff};
   always_comb begin
      sum_in = sum_ff;
      if (cmd.acc) sum_in = sum_wide[SB] ? {SB{1'b1}} : sum_wide[SB-1:0];
      if (cmd.out_load) sum_in = '0;
   end

   // digit-by-digit square root of sum scaled by 2^24
   always_comb begin
      logic [RREMB+1:0] trial;
      logic [RREMB+1:0] test;
      trial   = {rrem_ff, rad_ff[RADB-1 -: 2]};
      test    = (RREMB + 2)'({root_ff, 2'b01});
      rad_in  = rad_ff;
      rrem_in = rrem_ff;
      root_in = root_ff;
      if (cmd.sqrt_init) begin
         rad_in  = {sum_in, 24'd0};
         rrem_in = '0;
         root_in = '0;
      end else if (cmd.sqrt_step) begin
         rad_in = {rad_ff[RADB-3:0], 2'b00};
         if (trial >= test) begin
            rrem_in = RREMB'(trial - test);
            root_in = {root_ff[RB-2:0], 1'b1};
         end else begin
            rrem_in = trial[RREMB-1:0];
            root_in = {root_ff[RB-2:0], 1'b0};
         end
      end
   end

   // divide the root by the used count, one bit a step
   always_comb begin
      logic [QB:0] trial;
      trial   = {qrem_ff, qnum_ff[RB-1]};
      qnum_in = qnum_ff;
      qrem_in = qrem_ff;
      if (cmd.qdiv_init) begin
         qnum_in = root_in;
         qrem_in = '0;
      end else if (cmd.qdiv_step) begin
         if (trial >= {1'b0, count_ff}) begin
            qrem_in = QB'(trial - {1'b0, count_ff});
            qnum_in = {qnum_ff[RB-2:0], 1'b1};
         end else begin
            qrem_in = trial[QB-1:0];
            qnum_in = {qnum_ff[RB-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      dist_in      = dist_ff;
      rstat_in     = rstat_ff;
      rused_in     = rused_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rstat_in     = status_ff;
         rused_in     = count_ff;
         if (status_ff != hcd_pkg::STATUS_OK) dist_in = '0;
         else if (qnum_ff[RB-1:hcd_pkg::DIST_BITS] != '0) dist_in = '1;
         else dist_in = qnum_ff[hcd_pkg::DIST_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         status_ff    <= hcd_pkg::STATUS_OK;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         status_ff    <= status_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      r_ff    <= r_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      rad_ff  <= rad_in;
      rrem_ff <= rrem_in;
      root_ff <= root_in;
      qnum_ff <= qnum_in;
      qrem_ff <= qrem_in;
      dist_ff <= dist_in;
      rstat_ff <= rstat_in;
      rused_ff <= rused_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = dist_ff;
   assign rsp_status    = rstat_ff;
   assign rsp_used_bins = rused_ff;

   a_clear_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (count_ff == '0) && (sum_ff == '0))
      else $error("accumulation not cleared after result load");

   a_error_zero_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rstat_ff != hcd_pkg::STATUS_OK)) |-> (dist_ff == '0))
      else $error("nonzero distance with error status");

   a_index_restart: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && req_last_bin) |=> (idx_ff == '0))
      else $error("channel index not restarted after last bin");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending transaction");

endmodule

FILE: src/histogram_chi_distance.sv
// Top level: configuration registers, controller and datapath of the chi distance block.
//
// channel  direction  handshake                 payload
// req      in         req_valid / req_ready     measured_bin, reference_bin, last_bin
// rsp      out        rsp_valid / rsp_ready     distance, status, used_bins
// csr      in         psel/penable/pwrite       range_low at 0x0, range_high at 0x4
//
// A bin outside the range or with zero reference is taken in idle; a used bin goes
// through a multiply, the two-bit divider steps and an accumulate.
// A last bin with ok status adds the root steps and the count divider steps,
// and every last bin then loads the result register.
// Synchronous reset clears the index, the sum, the count and the result valid.
// A waiting result holds the block only when the next result is ready to load.
`timescale 1ns / 1ps
module histogram_chi_distance #(
   parameter int MAX_CHANNELS = hcd_pkg::MAX_CHANNELS_DEFAULT,
   parameter int BIN_WIDTH    = hcd_pkg::BIN_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [hcd_pkg::BIN_BITS-1:0]   req_measured_bin,
   input  logic [hcd_pkg::BIN_BITS-1:0]   req_reference_bin,
   input  logic                           req_last_bin,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [hcd_pkg::DIST_BITS-1:0]  rsp_distance,
   output logic [1:0]                     rsp_status,
   output logic [hcd_pkg::COUNT_BITS-1:0] rsp_used_bins,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [2:0]                     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   logic [hcd_pkg::RANGE_BITS-1:0] low_ff, low_in, high_ff, high_in;
   logic                           wr_en;
   hcd_pkg::cmd_type               cmd;
   hcd_pkg::sts_type               sts;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            hcd_pkg::REG_RANGE_LOW:  low_in  = csr_pwdata[hcd_pkg::RANGE_BITS-1:0];
            hcd_pkg::REG_RANGE_HIGH: high_in = csr_pwdata[hcd_pkg::RANGE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         hcd_pkg::REG_RANGE_LOW:  csr_prdata = 32'(low_ff);
         hcd_pkg::REG_RANGE_HIGH: csr_prdata = 32'(high_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '1;
      end else begin
         low_ff  <= low_in;
         high_ff <= high_in;
      end
   end

   hcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   hcd_dp #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .BIN_WIDTH    (BIN_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_measured_bin  (req_measured_bin),
      .req_reference_bin (req_reference_bin),
      .req_last_bin      (req_last_bin),
      .range_low         (low_ff),
      .range_high        (high_ff),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_distance      (rsp_distance),
      .rsp_status        (rsp_status),
      .rsp_used_bins     (rsp_used_bins)
   );

endmodule

FILE: tb/histogram_chi_distance_tb.sv
// Self-checking testbench for the histogram chi distance block.
`timescale 1ns / 1ps
module histogram_chi_distance_tb;

   localparam int          CHANNEL_LIMIT   = 16384;
   localparam int          SETTLE_CYCLES   = 160;
   localparam logic [2:0]  ADDR_RANGE_LOW  = {hcd_pkg::REG_RANGE_LOW, 2'b00};
   localparam logic [2:0]  ADDR_RANGE_HIGH = {hcd_pkg::REG_RANGE_HIGH, 2'b00};
   localparam logic [31:0] BIN_MAX         = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [hcd_pkg::DIST_BITS-1:0]  distance;
      logic [1:0]                     status;
      logic [hcd_pkg::COUNT_BITS-1:0] used_bins;
   } chi_result_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [hcd_pkg::BIN_BITS-1:0]   req_measured_bin = '0;
   logic [hcd_pkg::BIN_BITS-1:0]   req_reference_bin = '0;
   logic                           req_last_bin = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [hcd_pkg::DIST_BITS-1:0]  rsp_distance;
   logic [1:0]                     rsp_status;
   logic [hcd_pkg::COUNT_BITS-1:0] rsp_used_bins;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [2:0]                     csr_paddr = '0;
   logic [31:0]                    csr_pwdata = '0;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   // predictor state
   logic [hcd_pkg::RANGE_BITS-1:0] cfg_low = '0;
   logic [hcd_pkg::RANGE_BITS-1:0] cfg_high = '1;
   int                             chan_index = 0;
   logic [63:0]                    chi_sum = '0;
   int                             bins_used = 0;

   chi_result_type expected_results[$];
   int             mismatches = 0;
   int             send_idle_pct = 0;
   int             rsp_stall_pct = 0;
   int             hold_cycles = 0;

   histogram_chi_distance uut (.*);

   always #10 clock = ~clock;

   // receiver: long hold-off when requested, otherwise random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic report(string what, logic [63:0] exp_v, logic [63:0] act_v);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0h, got %0h", what, exp_v, act_v);
   endtask

   always @(posedge clock) begin
      chi_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report("unexpected transaction", 0, rsp_distance);
         end else begin
            want = expected_results.pop_front();
            if (rsp_distance !== want.distance)
               report("distance", want.distance, rsp_distance);
            if (rsp_status !== want.status)
               report("status", want.status, rsp_status);
            if (rsp_used_bins !== want.used_bins)
               report("used_bins", want.used_bins, rsp_used_bins);
         end
      end
   end

   // accumulate one bin and, on the last one, queue the spectrum result
   function automatic void predict_bin(logic [31:0] m, logic [31:0] r, logic last);
      logic [63:0]    d, term;
      logic [127:0]   scaled, cand;
      logic [47:0]    root;
      logic [63:0]    quot;
      chi_result_type res;
      if (chan_index < CHANNEL_LIMIT && chan_index >= cfg_low && chan_index <= cfg_high
          && r != 0) begin
         d = (m > r) ? 64'(m - r) : 64'(r - m);
         term = (d * d) / 64'(r);
         if (term > ~chi_sum) chi_sum = '1;
         else chi_sum += term;
         bins_used++;
      end
      if (!last) begin
         if (chan_index < CHANNEL_LIMIT) chan_index++;
         return;
      end
      res.distance = '0;
      res.used_bins = hcd_pkg::COUNT_BITS'(bins_used);
      if (cfg_low >= cfg_high) begin
         res.status = hcd_pkg::STATUS_BAD_RANGE;
      end else if (chan_index < cfg_high) begin
         res.status = hcd_pkg::STATUS_SHORT;
      end else if (bins_used == 0) begin
         res.status = hcd_pkg::STATUS_NO_BINS;
      end else begin
         res.status = hcd_pkg::STATUS_OK;
         scaled = {40'b0, chi_sum, 24'b0};
         root = '0;
         for (int k = 47; k >= 0; k--) begin
            cand = 128'(root | (48'd1 << k));
            if (cand * cand <= scaled) root = cand[47:0];
         end
         quot = 64'(root) / 64'(bins_used);
         res.distance = (quot > 64'(BIN_MAX)) ? BIN_MAX : quot[31:0];
      end
      expected_results.push_back(res);
      chan_index = 0;
      chi_sum = '0;
      bins_used = 0;
   endfunction

   // offer one bin; valid stays high afterwards until the next gap
   task automatic send_bin(logic [31:0] m, logic [31:0] r, logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_measured_bin <= m;
      req_reference_bin <= r;
      req_last_bin <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_bin(m, r, last);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(logic wr, logic [2:0] addr, logic [31:0] data,
                             output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // write both range registers and read them back; block must be idle
   task automatic set_range(int low, int high);
      logic [31:0] rd;
      csr_access(1'b1, ADDR_RANGE_LOW, 32'(low), rd);
      csr_access(1'b1, ADDR_RANGE_HIGH, 32'(high), rd);
      cfg_low = hcd_pkg::RANGE_BITS'(low);
      cfg_high = hcd_pkg::RANGE_BITS'(high);
      csr_access(1'b0, ADDR_RANGE_LOW, '0, rd);
      if (rd[hcd_pkg::RANGE_BITS-1:0] !== cfg_low)
         report("range_low readback", cfg_low, rd);
      csr_access(1'b0, ADDR_RANGE_HIGH, '0, rd);
      if (rd[hcd_pkg::RANGE_BITS-1:0] !== cfg_high)
         report("range_high readback", cfg_high, rd);
   endtask

   function automatic logic [31:0] rand_bin();
      case ($urandom_range(3))
         0: return $urandom_range(4095);
         1: return $urandom;
         2: return $urandom_range(1 << 20);
         default: return 32'($urandom_range(255)) << $urandom_range(24);
      endcase
   endfunction

   task automatic send_spectrum(int len, int zero_pct);
      logic [31:0] m, r;
      for (int i = 0; i < len; i++) begin
         r = ($urandom_range(99) < zero_pct) ? 32'd0 : rand_bin();
         m = ($urandom_range(9) == 0) ? r : rand_bin();
         send_bin(m, r, i == len - 1);
      end
   endtask

   task automatic test_reset_values();
      logic [31:0] rd;
      csr_access(1'b0, ADDR_RANGE_LOW, '0, rd);
      if (rd[hcd_pkg::RANGE_BITS-1:0] !== 14'd0) report("range_low reset", 0, rd);
      csr_access(1'b0, ADDR_RANGE_HIGH, '0, rd);
      if (rd[hcd_pkg::RANGE_BITS-1:0] !== 14'h3FFF)
         report("range_high reset", 14'h3FFF, rd);
      // default range with a short spectrum reports the stream as too short
      send_bin(32'd100, 32'd50, 1'b0);
      send_bin(32'd0, 32'd1, 1'b1);
      drain();
   endtask

   task automatic test_directed();
      set_range(2, 5);
      send_bin(32'd7, 32'd0, 1'b0);
      send_bin(BIN_MAX, BIN_MAX, 1'b0);
      send_bin(32'd0, BIN_MAX, 1'b0);
      send_bin(BIN_MAX, 32'd256, 1'b0);
      send_bin(32'd512, 32'd0, 1'b0);
      send_bin(32'd1, 32'd3, 1'b0);
      send_bin(32'd9, 32'd9, 1'b1);
      // ends before the high channel
      send_bin(32'd5, 32'd4, 1'b0);
      send_bin(32'd5, 32'd4, 1'b0);
      send_bin(32'd5, 32'd4, 1'b1);
      // in range but every reference is zero
      for (int i = 0; i < 6; i++) send_bin(32'd11, 32'd0, i == 5);
      drain();
      set_range(3, 3);
      for (int i = 0; i < 4; i++) send_bin(32'd20, 32'd10, i == 3);
      drain();
      // huge terms drive the sum into saturation
      set_range(0, 1);
      send_bin(BIN_MAX, 32'd1, 1'b0);
      send_bin(BIN_MAX, 32'd1, 1'b1);
      send_bin(32'd0, 32'd1, 1'b0);
      send_bin(32'd1, 32'd1, 1'b1);
      drain();
   endtask

   task automatic test_long_stream();
      logic [31:0] r;
      set_range(60, 95);
      for (int i = 0; i < 100; i++) begin
         r = (i >= 58) ? rand_bin() | 32'd1 : 32'd0;
         send_bin(rand_bin(), r, i == 99);
      end
      drain();
      set_range(16383, 16383);
      send_spectrum(3, 0);
      drain();
   endtask

   task automatic test_random_spectra(int idle_pct, int stall_pct, int count);
      int lo;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         if (n % 8 == 0) begin
            drain();
            lo = $urandom_range(5);
            case ($urandom_range(5))
               0: set_range(lo, lo);
               1: set_range(lo + 1, lo);
               2: set_range(0, 16383);
               default: set_range(lo, lo + $urandom_range(1, 8));
            endcase
         end
         send_spectrum($urandom_range(1, cfg_high < 16 ? cfg_high + 3 : 12),
                       $urandom_range(40));
      end
      drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_range(0, 1);
      hold_cycles = 1500;
      for (int n = 0; n < 12; n++) begin
         send_bin(32'd3, 32'd0, 1'b0);
         send_bin(32'd300, 32'd200, 1'b0);
         send_bin(32'd8, 32'd0, 1'b1);
      end
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed();
      test_long_stream();
      test_random_spectra(23, 70, 60);
      test_random_spectra(70, 23, 60);
      test_random_spectra(0, 0, 60);
      test_backpressure();
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: histogram_chi_distance.f
src/hcd_pkg.sv
src/hcd_ctrl.sv
src/hcd_dp.sv
src/histogram_chi_distance.sv
tb/histogram_chi_distance_tb.sv
